FILE: rtl/core/mm3_pkg.sv
// Package for the MurmurHash3 x86_32 hash core.
// Holds mixing constants, controller/datapath interface types and helpers.
// No dependencies.
package mm3_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 3;

  localparam logic [WordW-1:0] MixC1 = 32'hcc9e2d51;
  localparam logic [WordW-1:0] MixC2 = 32'h1b873593;
  localparam logic [WordW-1:0] MixN  = 32'he6546b64;
  localparam logic [WordW-1:0] FinF1 = 32'h85ebca6b;
  localparam logic [WordW-1:0] FinF2 = 32'hc2b2ae35;

  localparam logic [CountW-1:0] FullBytes = 3'd4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic key_start;
    logic mul1;
    logic mul2;
    logic mix;
    logic fin1;
    logic fin2;
    logic emit;
  } mm3_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last;
  } mm3_status_t;

  function automatic logic [WordW-1:0] byte_mask(input logic [CountW-1:0] nb);
    logic [WordW-1:0] m;
    unique case (nb)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/core/murmur3_32_hash_core.sv
// Top level of the MurmurHash3 x86_32 hash core.
// Instantiates mm3_ctrl and mm3_datapath; uses mm3_pkg.
//
//   channel  handshake               payload
//   input    in_valid_i/in_ready_o   data_word_i, valid_bytes_i, last_word_i
//   output   out_valid_o/out_ready_i hash_value_o
//   config   cfg_we_i                cfg_wdata_i (seed)
//
// A word that is not last passes through accept, two multiplier steps and mix.
// A last word adds two finalisation multiplier steps and the output state, which
// waits for the output register to free; each multiplier step is its own state.
// A finished hash waits in the output register while the next key's words
// are accepted. Reset clears the seed, the controller and the output valid.
module murmur3_32_hash_core
  import mm3_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [WordW-1:0]  cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [WordW-1:0]  data_word_i,
  input  logic [CountW-1:0] valid_bytes_i,
  input  logic              last_word_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [WordW-1:0]  hash_value_o
);

  mm3_cmd_t    cmd;
  mm3_status_t status;

  mm3_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mm3_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .data_word_i   (data_word_i),
    .valid_bytes_i (valid_bytes_i),
    .last_word_i   (last_word_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .hash_value_o  (hash_value_o)
  );

endmodule

FILE: rtl/core/mm3_datapath.sv
// Datapath of the MurmurHash3 core: seed register, running hash, byte count,
// four 32x32 multiplies into a work register and the result register. Uses mm3_pkg.
module mm3_datapath
  import mm3_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [WordW-1:0]  cfg_wdata_i,
  input  logic [WordW-1:0]  data_word_i,
  input  logic [CountW-1:0] valid_bytes_i,
  input  logic              last_word_i,
  input  mm3_cmd_t          cmd_i,
  output mm3_status_t       status_o,
  output logic [WordW-1:0]  hash_value_o
);

  logic [WordW-1:0]  seed_q;
  logic [WordW-1:0]  work_q, work_d;
  logic [WordW-1:0]  hash_q, hash_d;
  logic [WordW-1:0]  total_q, total_d;
  logic [WordW-1:0]  out_q, out_d;
  logic [CountW-1:0] nb_q, nb_d;
  logic              last_q, last_d;

  logic [CountW-1:0] nb_in;
  logic [WordW-1:0]  rot15, rot13, hx, fin_in, fin_a, fin_b;

  always_comb begin
    if (!last_word_i || (valid_bytes_i > FullBytes)) begin
      nb_in = FullBytes;
    end else begin
      nb_in = valid_bytes_i;
    end
  end

  assign rot15  = {work_q[WordW-16:0], work_q[WordW-1:WordW-15]};
  assign hx     = hash_q ^ work_q;
  assign rot13  = {hx[WordW-14:0], hx[WordW-1:WordW-13]};
  assign fin_in = hash_q ^ total_q;
  assign fin_a  = fin_in ^ (fin_in >> 16);
  assign fin_b  = work_q ^ (work_q >> 13);

  always_comb begin
    work_d  = work_q;
    hash_d  = hash_q;
    total_d = total_q;
    out_d   = out_q;
    nb_d    = nb_q;
    last_d  = last_q;
    priority if (cmd_i.load) begin
      work_d = data_word_i & byte_mask(nb_in);
      nb_d   = nb_in;
      last_d = last_word_i;
      if (cmd_i.key_start) begin
        hash_d  = seed_q;
        total_d = '0;
      end
    end else if (cmd_i.mul1) begin
      work_d = work_q * MixC1;
    end else if (cmd_i.mul2) begin
      work_d = rot15 * MixC2;
    end else if (cmd_i.mix) begin
      if (nb_q == FullBytes) begin
        hash_d = (rot13 << 2) + rot13 + MixN;
      end else begin
        hash_d = hx;
      end
      total_d = total_q + {{(WordW-CountW){1'b0}}, nb_q};
    end else if (cmd_i.fin1) begin
      work_d = fin_a * FinF1;
    end else if (cmd_i.fin2) begin
      work_d = fin_b * FinF2;
    end else if (cmd_i.emit) begin
      out_d = work_q ^ (work_q >> 16);
    end else begin
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_we_i) begin
      seed_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q  <= work_d;
    hash_q  <= hash_d;
    total_q <= total_d;
    out_q   <= out_d;
    nb_q    <= nb_d;
    last_q  <= last_d;
  end

  assign status_o.last = last_q;
  assign hash_value_o  = out_q;

endmodule

FILE: rtl/core/mm3_ctrl.sv
// Controller of the MurmurHash3 core: sequences one word through the
// datapath and owns both handshakes. Uses mm3_pkg.
module mm3_ctrl
  import mm3_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  mm3_status_t status_i,
  output mm3_cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    StIdle = 7'b000_0001,
    StMul1 = 7'b000_0010,
    StMul2 = 7'b000_0100,
    StMix  = 7'b000_1000,
    StFin1 = 7'b001_0000,
    StFin2 = 7'b010_0000,
    StOut  = 7'b100_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   key_open_q, key_open_d;
  logic   accept, emit;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign emit       = (state_q == StOut) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (accept) state_d = StMul1;
      StMul1: state_d = StMul2;
      StMul2: state_d = StMix;
      StMix:  state_d = status_i.last ? StFin1 : StIdle;
      StFin1: state_d = StFin2;
      StFin2: state_d = StOut;
      StOut:  if (emit) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = accept;
    cmd_o.key_start = accept && !key_open_q;
    cmd_o.mul1      = (state_q == StMul1);
    cmd_o.mul2      = (state_q == StMul2);
    cmd_o.mix       = (state_q == StMix);
    cmd_o.fin1      = (state_q == StFin1);
    cmd_o.fin2      = (state_q == StFin2);
    cmd_o.emit      = emit;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    key_open_d = key_open_q;
    if (accept) begin
      key_open_d = 1'b1;
    end else if (emit) begin
      key_open_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      key_open_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      key_open_q  <= key_open_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
